[src/cri_pkg.sv]
package cri_pkg;
  localparam int MAX_STOPS_D = 16;
  localparam int FRACTION_BITS_D = 16;
  localparam int CHANNEL_BITS_D = 8;
  localparam int POS_BITS = 32;
  localparam logic [0:0] CFG_DIVERGING = 1'b0;
  localparam logic [0:0] CFG_STOP_COUNT = 1'b1;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;
endpackage

[src/cri_divider.sv]
// Restoring divider: quotient = floor(num / den), one bit per cycle.
module cri_divider import cri_pkg::*; #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic run_r, run_nxt, done_r, done_nxt;
  logic [W:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[W-1]} - {1'b0, den_r};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      cnt_nxt = CW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo = quo_r;
endmodule

[src/cri_stop_table.sv]
// Stop table: position and color memories, one write and one read port each.
module cri_stop_table import cri_pkg::*; #(
  parameter int MAX_STOPS = MAX_STOPS_D,
  parameter int CHANNEL_BITS = CHANNEL_BITS_D,
  localparam int IW = $clog2(MAX_STOPS)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [IW-1:0]             waddr,
  input  logic [POS_BITS-1:0]       wpos,
  input  logic [3*CHANNEL_BITS-1:0] wcolor,
  input  logic [IW-1:0]             raddr,
  output logic [POS_BITS-1:0]       rpos,
  output logic [3*CHANNEL_BITS-1:0] rcolor
);
  logic [POS_BITS-1:0] pos_mem [MAX_STOPS];
  logic [3*CHANNEL_BITS-1:0] col_mem [MAX_STOPS];

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr] <= wpos;
      col_mem[waddr] <= wcolor;
    end
    rpos <= pos_mem[raddr];
    rcolor <= col_mem[raddr];
  end
endmodule

[src/color_ramp_interpolator.sv]
// Color ramp interpolator.
// Words enter on the command channel: start is taken when busy is low. A word
// with op load writes one color stop into the table, gives no result and
// leaves busy low, so the next word can follow at the next edge.
// A word with op lookup maps lookup_value to a color. The result appears on the
// out_ ports for one cycle, marked by out_valid. The receiver cannot stall, so
// results are never held back.
// A ramp lookup reads entry 0 and the last entry first. It then walks the
// table one entry per cycle over the memory read port, visiting up to
// MAX_STOPS - 1 entries. A blend runs the 48 bit restoring divider once per
// channel. Some results take the color of a stop without a blend: clamped,
// a single stop, an empty segment or the last stop. Busy is low in the
// strobe cycle, so a new word can be taken at its end.
// Configuration words (diverging_mode, stop_count) arrive on the cfg_
// channel, always ready, and should only be written while busy is low.
// Synchronous reset clears the control state and both registers; the stop
// table itself is undefined until loaded.
module color_ramp_interpolator import cri_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_D,
  parameter int CHANNEL_BITS = CHANNEL_BITS_D
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_op,
  input  logic [3:0]              in_stop_index,
  input  logic signed [31:0]      in_stop_position,
  input  logic [CHANNEL_BITS-1:0] in_stop_red,
  input  logic [CHANNEL_BITS-1:0] in_stop_green,
  input  logic [CHANNEL_BITS-1:0] in_stop_blue,
  input  logic signed [31:0]      in_lookup_value,
  output logic                    out_valid,
  output logic [CHANNEL_BITS-1:0] out_red,
  output logic [CHANNEL_BITS-1:0] out_green,
  output logic [CHANNEL_BITS-1:0] out_blue,
  output logic                    out_below_range,
  output logic                    out_above_range,
  output logic [3:0]              out_segment,
  output logic                    out_empty_white,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [4:0]              cfg_data
);
  localparam int MAX_STOPS = MAX_STOPS_D;
  localparam int IW = $clog2(MAX_STOPS);
  localparam int CNTW = $clog2(MAX_STOPS + 1);
  localparam int CB = CHANNEL_BITS;
  localparam int DW = CB + 40;
  localparam logic [CB-1:0] WHITE = {CB{1'b1}};

  localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_FIRST = 4'd2,
    S_LAST = 4'd3, S_SCAN = 4'd4, S_RDLO = 4'd5, S_GETLO = 4'd6,
    S_GETHI = 4'd7, S_DIV = 4'd8, S_WAIT = 4'd9, S_OUT = 4'd10,
    S_RDLAST = 4'd11, S_SOLID = 4'd12;

  logic [3:0] st_r, st_nxt;
  logic div_r, div_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic signed [31:0] t_r, t_nxt;
  logic signed [32:0] lo_pos_r, lo_pos_nxt;
  logic [IW-1:0] idx_r, idx_nxt, raddr;
  logic [CNTW-1:0] n_eff;
  logic [3*CB-1:0] lo_col_r, lo_col_nxt, hi_col_r, hi_col_nxt;
  logic [DW-1:0] nn_r, nn_nxt, dd_r, dd_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic [CB-1:0] rgb_r [3], rgb_nxt [3];
  logic below_r, below_nxt, above_r, above_nxt, empty_r, empty_nxt;
  logic [3:0] seg_r, seg_nxt;
  logic ov_r, ov_nxt;
  logic [POS_BITS-1:0] rpos;
  logic [3*CB-1:0] rcolor;
  logic dv_start, dv_done;
  logic [DW-1:0] dv_num, dv_quo, acc;
  logic [CB-1:0] clo, chi;
  logic signed [32:0] dnum, dden;
  logic load_we;

  assign cfg_ready = 1'b1;
  assign busy = (st_r != S_IDLE);
  assign n_eff = (cnt_r > CNTW'(MAX_STOPS)) ? CNTW'(MAX_STOPS) : cnt_r;
  assign load_we = start && !busy && in_op == OP_LOAD && 32'(in_stop_index) < MAX_STOPS;

  cri_stop_table #(.MAX_STOPS(MAX_STOPS), .CHANNEL_BITS(CB)) u_table (
    .clk(clk), .we(load_we), .waddr(in_stop_index[IW-1:0]),
    .wpos(in_stop_position), .wcolor({in_stop_blue, in_stop_green, in_stop_red}),
    .raddr(raddr), .rpos(rpos), .rcolor(rcolor));

  // Blend accumulator: lo*(d-n) + hi*n, rounded as (2acc+d)/(2d).
  always_comb begin
    clo = lo_col_r[ch_r*CB +: CB];
    chi = hi_col_r[ch_r*CB +: CB];
    acc = DW'(clo) * (dd_r - nn_r) + DW'(chi) * nn_r;
    dv_num = {acc[DW-2:0], 1'b0} + dd_r;
  end

  cri_divider #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num),
    .den({dd_r[DW-2:0], 1'b0}), .done(dv_done), .quo(dv_quo));

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; t_nxt = t_r; lo_pos_nxt = lo_pos_r;
    lo_col_nxt = lo_col_r; hi_col_nxt = hi_col_r; nn_nxt = nn_r; dd_nxt = dd_r;
    ch_nxt = ch_r; rgb_nxt = rgb_r; below_nxt = below_r; above_nxt = above_r;
    empty_nxt = empty_r; seg_nxt = seg_r; ov_nxt = 1'b0;
    div_nxt = div_r; cnt_nxt = cnt_r; raddr = idx_r; dv_start = 1'b0;
    dnum = 33'(t_r) - lo_pos_r;
    dden = 33'(signed'(rpos)) - lo_pos_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_DIVERGING) div_nxt = cfg_data[0];
      else cnt_nxt = cfg_data[CNTW-1:0];
    end
    unique case (st_r)
      S_IDLE: begin
        if (start && in_op == OP_LOOKUP) begin
          below_nxt = 1'b0; above_nxt = 1'b0; empty_nxt = 1'b0; seg_nxt = '0;
          t_nxt = in_lookup_value; ch_nxt = '0;
          idx_nxt = '0; raddr = '0;
          if (div_r) begin
            dd_nxt = DW'(1) << FRACTION_BITS;
            if (in_lookup_value < 0) begin
              below_nxt = 1'b1; nn_nxt = '0; idx_nxt = '0;
            end else if (in_lookup_value > (32'sd1 <<< FRACTION_BITS)) begin
              above_nxt = 1'b1; seg_nxt = 4'd1; idx_nxt = IW'(1);
              nn_nxt = DW'(1) << FRACTION_BITS;
            end else if ((33'(in_lookup_value) <<< 1) < (33'sd1 <<< FRACTION_BITS)) begin
              nn_nxt = DW'(in_lookup_value) << 1; idx_nxt = '0;
            end else begin
              seg_nxt = 4'd1; idx_nxt = IW'(1);
              nn_nxt = (DW'(in_lookup_value) << 1) - (DW'(1) << FRACTION_BITS);
            end
            st_nxt = S_RDLO;
          end else if (n_eff == '0) begin
            empty_nxt = 1'b1;
            for (int k = 0; k < 3; k++) rgb_nxt[k] = WHITE;
            st_nxt = S_OUT;
          end else begin
            st_nxt = S_RD0;
          end
        end
      end
      S_RD0: begin
        // Entry 0 is read again so that it lands in S_FIRST.
        st_nxt = S_FIRST;
      end
      S_FIRST: begin
        lo_col_nxt = rcolor;
        if (n_eff == CNTW'(1)) st_nxt = S_SOLID;
        else if (t_r < signed'(rpos)) begin
          below_nxt = 1'b1; st_nxt = S_SOLID;
        end else st_nxt = S_LAST;
        raddr = IW'(n_eff - 1'b1);
      end
      S_LAST: begin
        // Last entry data available. A value equal to it still walks the table,
        // since an unordered table can hold an earlier matching segment.
        if (t_r > signed'(rpos)) begin
          lo_col_nxt = rcolor; above_nxt = 1'b1;
          st_nxt = S_SOLID;
        end else begin
          idx_nxt = '0; raddr = '0; st_nxt = S_RDLO;
          ch_nxt = 2'd3;
        end
      end
      S_RDLO: begin
        raddr = idx_r;
        st_nxt = (ch_r == 2'd3) ? S_SCAN : S_GETLO;
        if (ch_r == 2'd3) begin
          // Entry 0 is on the read port: it opens the first segment.
          lo_pos_nxt = 33'(signed'(rpos)); lo_col_nxt = rcolor;
          idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1;
        end
      end
      S_SCAN: begin
        // rpos is entry idx_r and lo_pos_r holds entry idx_r - 1.
        if (t_r < signed'(rpos)) begin
          seg_nxt = 4'(idx_r - 1'b1);
          if (dden <= 0 || dnum <= 0) st_nxt = S_SOLID;
          else begin
            hi_col_nxt = rcolor; nn_nxt = DW'(dnum);
            dd_nxt = DW'(dden); ch_nxt = '0; st_nxt = S_DIV;
          end
        end else if (idx_r == IW'(n_eff - 1'b1)) begin
          // No segment matched: the last color, reported as the last segment.
          lo_col_nxt = rcolor; seg_nxt = 4'(n_eff - 2'd2);
          st_nxt = S_SOLID;
        end else begin
          lo_pos_nxt = 33'(signed'(rpos)); lo_col_nxt = rcolor;
          idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1;
        end
      end
      S_GETLO: begin
        lo_col_nxt = rcolor; idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1;
        st_nxt = S_GETHI;
      end
      S_GETHI: begin
        st_nxt = S_WAIT; ch_nxt = 2'd0;
      end
      S_WAIT: begin
        hi_col_nxt = rcolor; st_nxt = S_DIV;
      end
      S_DIV: begin
        dv_start = 1'b1; st_nxt = S_RDLAST;
      end
      S_RDLAST: begin
        if (dv_done) begin
          rgb_nxt[ch_r] = dv_quo[CB-1:0];
          if (ch_r == 2'd2) st_nxt = S_OUT;
          else begin
            ch_nxt = ch_r + 1'b1; st_nxt = S_DIV;
          end
        end
      end
      S_SOLID: begin
        for (int k = 0; k < 3; k++) rgb_nxt[k] = lo_col_r[k*CB +: CB];
        st_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; div_r <= 1'b0; cnt_r <= '0;
      ch_r <= '0; seg_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; div_r <= div_nxt; cnt_r <= cnt_nxt;
      ch_r <= ch_nxt; seg_r <= seg_nxt;
    end
    idx_r <= idx_nxt; t_r <= t_nxt; lo_pos_r <= lo_pos_nxt;
    lo_col_r <= lo_col_nxt; hi_col_r <= hi_col_nxt; nn_r <= nn_nxt; dd_r <= dd_nxt;
    rgb_r <= rgb_nxt; below_r <= below_nxt; above_r <= above_nxt; empty_r <= empty_nxt;
  end

  assign out_valid = ov_r;
  assign out_red = rgb_r[0];
  assign out_green = rgb_r[1];
  assign out_blue = rgb_r[2];
  assign out_below_range = below_r;
  assign out_above_range = above_r;
  assign out_segment = seg_r;
  assign out_empty_white = empty_r;
endmodule
